### hdl/coalescing_free_range_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the coalescing free range allocator
// Shared property templates with a common clock and reset gating.
// ----------------------------------------------------------------------------
`ifndef COALESCING_FREE_RANGE_ALLOCATOR_MACROS_SVH
`define COALESCING_FREE_RANGE_ALLOCATOR_MACROS_SVH

// Condition a implies condition b in the same cycle.
`define CFRA_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("cfra same-cycle check failed");

// Condition a implies condition b in the next cycle.
`define CFRA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("cfra next-cycle check failed");

`endif

### hdl/cfra_pkg.sv
// ----------------------------------------------------------------------------
// cfra_pkg
// Types, codes and sizes shared by the free range allocator modules.
// ----------------------------------------------------------------------------
package cfra_pkg;

    localparam int MAX_RANGES = 64;
    localparam int ADDR_BITS  = 32;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    // Operation codes.
    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_TAKE = 2'd1;
    localparam logic [1:0] MODE_FIND = 2'd2;

    // Result status codes.
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_OVERLAP  = 3'd1;
    localparam logic [2:0] STAT_NOT_FREE = 3'd2;
    localparam logic [2:0] STAT_FULL     = 3'd3;
    localparam logic [2:0] STAT_NO_FIT   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_DECIDE,
        ST_WRITE1,
        ST_SHIFT,
        ST_SHIFT_DRAIN,
        ST_WRITE2,
        ST_DONE
    } ctl_state_t;

    typedef enum logic [1:0] {
        SHIFT_NONE,
        SHIFT_DOWN,
        SHIFT_UP
    } shift_dir_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_rd;
        logic decide;
        logic write1;
        logic shift_rd;
        logic write2;
        logic done;
    } cfra_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_end;
        logic shift_end;
    } cfra_stat_t;

endpackage

### hdl/cfra_ctrl.sv
// ----------------------------------------------------------------------------
// cfra_ctrl
// Sequencer: scan the table, decide, write, shift the table, write, report.
// ----------------------------------------------------------------------------
module cfra_ctrl
    import cfra_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  cfra_stat_t stat,
    output cfra_cmd_t  cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_end)
                begin
                    state_next = ST_SCAN_DRAIN;
                end
            end
            ST_SCAN_DRAIN:  state_next = ST_DECIDE;
            ST_DECIDE:      state_next = ST_WRITE1;
            ST_WRITE1:      state_next = ST_SHIFT;
            ST_SHIFT:
            begin
                if (stat.shift_end)
                begin
                    state_next = ST_SHIFT_DRAIN;
                end
            end
            ST_SHIFT_DRAIN: state_next = ST_WRITE2;
            ST_WRITE2:      state_next = ST_DONE;
            ST_DONE:        state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd      = '0;
        busy     = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:     cmd.load     = start;
            ST_SCAN:     cmd.scan_rd  = !stat.scan_end;
            ST_DECIDE:   cmd.decide   = 1'b1;
            ST_WRITE1:   cmd.write1   = 1'b1;
            ST_SHIFT:    cmd.shift_rd = !stat.shift_end;
            ST_WRITE2:   cmd.write2   = 1'b1;
            ST_DONE:     cmd.done     = 1'b1;
            default:     cmd          = '0;
        endcase
    end

endmodule

### hdl/cfra_dp.sv
// ----------------------------------------------------------------------------
// cfra_dp
// Range table memory, scan registers, operation planning and result registers.
// ----------------------------------------------------------------------------
module cfra_dp
    import cfra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfra_cmd_t   cmd,
    output cfra_stat_t  stat,
    input  logic [1:0]  mode,
    input  logic [31:0] range_start,
    input  logic [31:0] range_size,
    output logic        done,
    output logic [31:0] found_offset,
    output logic [2:0]  status,
    output logic [6:0]  range_count
);

    `include "coalescing_free_range_allocator_macros.svh"

    // Range table: first and last address of each range.
    addr_t mem_start [MAX_RANGES];
    addr_t mem_last  [MAX_RANGES];

    // Captured operation.
    logic [1:0] mode_reg;
    addr_t      s_reg;
    addr_t      l_reg;
    addr_t      szm1_reg;
    logic       zero_reg;
    cnt_t       count_reg;
    cnt_t       ptr_reg;

    // Read port.
    logic  rd_scan_reg;
    logic  rd_shift_reg;
    idx_t  rd_idx_reg;
    addr_t rd_start_reg;
    addr_t rd_last_reg;

    // Scan results.
    logic  has_prev_reg;
    addr_t prev_start_reg;
    addr_t prev_last_reg;
    cnt_t  pos_reg;
    logic  has_next_reg;
    addr_t next_start_reg;
    addr_t next_last_reg;
    logic  has_best_reg;
    addr_t best_size_reg;
    addr_t best_last_reg;

    // Registered plan.
    logic       w1_en_start_reg;
    logic       w1_en_last_reg;
    idx_t       w1_idx_reg;
    addr_t      w1_start_reg;
    addr_t      w1_last_reg;
    shift_dir_t dir_reg;
    cnt_t       shift_lo_reg;
    logic       w2_en_reg;
    idx_t       w2_idx_reg;
    addr_t      w2_start_reg;
    addr_t      w2_last_reg;
    logic       inc_reg;
    logic       dec_reg;
    logic [2:0] stat_reg;
    addr_t      offset_reg;

    // Result registers.
    logic        done_reg;
    logic [31:0] found_offset_reg;
    logic [2:0]  status_reg;
    logic [6:0]  range_count_reg;

    // Plan, combinational.
    logic       p_w1_en_start;
    logic       p_w1_en_last;
    cnt_t       p_w1_pos;
    addr_t      p_w1_start;
    addr_t      p_w1_last;
    shift_dir_t p_dir;
    cnt_t       p_ptr;
    logic       p_w2_en;
    addr_t      p_w2_start;
    addr_t      p_w2_last;
    logic       p_inc;
    logic       p_dec;
    logic [2:0] p_stat;
    addr_t      p_offset;

    logic [ADDR_BITS:0] sum_l;
    addr_t              rd_size;
    cnt_t               pos_m1;
    logic               ov;
    logic               jp;
    logic               jn;
    logic               nf;
    logic               eq_first;
    logic               eq_last;

    // Memory read address and write port.
    idx_t  rd_addr;
    cnt_t  ptr_m1;
    logic  wr_en_start;
    logic  wr_en_last;
    idx_t  wr_idx;
    addr_t wr_start;
    addr_t wr_last;

    assign sum_l   = {1'b0, range_start} + {1'b0, range_size - 32'd1};
    assign rd_size = rd_last_reg - rd_start_reg;
    assign pos_m1  = pos_reg - cnt_t'(1);
    assign ptr_m1  = ptr_reg - cnt_t'(1);

    // Status toward the controller.
    always_comb
    begin
        stat.scan_end = (ptr_reg >= count_reg);
        unique case (dir_reg)
            SHIFT_DOWN: stat.shift_end = (ptr_reg >= count_reg);
            SHIFT_UP:   stat.shift_end = (ptr_reg <= shift_lo_reg);
            default:    stat.shift_end = 1'b1;
        endcase
    end

    // Read address: scans and downward shifts read at the pointer,
    // upward shifts read one below it.
    assign rd_addr = (dir_reg == SHIFT_UP && cmd.shift_rd) ? ptr_m1[IDX_W-1:0]
                                                           : ptr_reg[IDX_W-1:0];

    // Write port selection; shift writes never meet the plan writes.
    always_comb
    begin
        wr_en_start = 1'b0;
        wr_en_last  = 1'b0;
        wr_idx      = w1_idx_reg;
        wr_start    = w1_start_reg;
        wr_last     = w1_last_reg;
        priority if (rd_shift_reg)
        begin
            wr_en_start = 1'b1;
            wr_en_last  = 1'b1;
            wr_idx      = (dir_reg == SHIFT_UP) ? rd_idx_reg + idx_t'(1)
                                                : rd_idx_reg - idx_t'(1);
            wr_start    = rd_start_reg;
            wr_last     = rd_last_reg;
        end
        else if (cmd.write1)
        begin
            wr_en_start = w1_en_start_reg;
            wr_en_last  = w1_en_last_reg;
        end
        else if (cmd.write2)
        begin
            wr_en_start = w2_en_reg;
            wr_en_last  = w2_en_reg;
            wr_idx      = w2_idx_reg;
            wr_start    = w2_start_reg;
            wr_last     = w2_last_reg;
        end
    end

    // Range table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en_start)
        begin
            mem_start[wr_idx] <= wr_start;
        end
        if (wr_en_last)
        begin
            mem_last[wr_idx] <= wr_last;
        end
        if (cmd.scan_rd || cmd.shift_rd)
        begin
            rd_start_reg <= mem_start[rd_addr];
            rd_last_reg  <= mem_last[rd_addr];
            rd_idx_reg   <= rd_addr;
        end
    end

    // Read tags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_scan_reg  <= 1'b0;
            rd_shift_reg <= 1'b0;
        end
        else
        begin
            rd_scan_reg  <= cmd.scan_rd;
            rd_shift_reg <= cmd.shift_rd;
        end
    end

    // Plan of the operation from the scan results.
    always_comb
    begin
        p_w1_en_start = 1'b0;
        p_w1_en_last  = 1'b0;
        p_w1_pos      = pos_m1;
        p_w1_start    = s_reg;
        p_w1_last     = l_reg;
        p_dir         = SHIFT_NONE;
        p_ptr         = count_reg;
        p_w2_en       = 1'b0;
        p_w2_start    = s_reg;
        p_w2_last     = l_reg;
        p_inc         = 1'b0;
        p_dec         = 1'b0;
        p_stat        = STAT_OK;
        p_offset      = '0;
        ov = (has_prev_reg && prev_last_reg >= s_reg)
            || (has_next_reg && next_start_reg <= l_reg);
        jp = has_prev_reg
            && ({1'b0, prev_last_reg} + 1'b1) == {1'b0, s_reg};
        jn = has_next_reg
            && ({1'b0, l_reg} + 1'b1) == {1'b0, next_start_reg};
        nf = !has_prev_reg || s_reg > prev_last_reg || l_reg > prev_last_reg;
        eq_first = (s_reg == prev_start_reg);
        eq_last  = (l_reg == prev_last_reg);
        if (!zero_reg)
        begin
            unique case (mode_reg)
                MODE_ADD:
                begin
                    priority if (ov)
                    begin
                        p_stat = STAT_OVERLAP;
                    end
                    else if (jp && jn)
                    begin
                        p_w1_en_last = 1'b1;
                        p_w1_last    = next_last_reg;
                        p_dir        = SHIFT_DOWN;
                        p_ptr        = pos_reg + cnt_t'(1);
                        p_dec        = 1'b1;
                    end
                    else if (jp)
                    begin
                        p_w1_en_last = 1'b1;
                    end
                    else if (jn)
                    begin
                        p_w1_en_start = 1'b1;
                        p_w1_pos      = pos_reg;
                    end
                    else if (count_reg == cnt_t'(MAX_RANGES))
                    begin
                        p_stat = STAT_FULL;
                    end
                    else
                    begin
                        p_dir   = SHIFT_UP;
                        p_w2_en = 1'b1;
                        p_inc   = 1'b1;
                    end
                end
                MODE_TAKE:
                begin
                    priority if (nf)
                    begin
                        p_stat = STAT_NOT_FREE;
                    end
                    else if (eq_first && eq_last)
                    begin
                        p_dir = SHIFT_DOWN;
                        p_ptr = pos_reg;
                        p_dec = 1'b1;
                    end
                    else if (eq_first)
                    begin
                        p_w1_en_start = 1'b1;
                        p_w1_start    = l_reg + addr_t'(1);
                    end
                    else if (eq_last)
                    begin
                        p_w1_en_last = 1'b1;
                        p_w1_last    = s_reg - addr_t'(1);
                    end
                    else if (count_reg == cnt_t'(MAX_RANGES))
                    begin
                        p_stat = STAT_FULL;
                    end
                    else
                    begin
                        p_w1_en_last = 1'b1;
                        p_w1_last    = s_reg - addr_t'(1);
                        p_dir        = SHIFT_UP;
                        p_w2_en      = 1'b1;
                        p_w2_start   = l_reg + addr_t'(1);
                        p_w2_last    = prev_last_reg;
                        p_inc        = 1'b1;
                    end
                end
                MODE_FIND:
                begin
                    if (!has_best_reg || szm1_reg > best_size_reg)
                    begin
                        p_stat = STAT_NO_FIT;
                    end
                    else
                    begin
                        p_offset = best_last_reg - szm1_reg;
                    end
                end
                default:
                begin
                    p_stat = STAT_OK;
                end
            endcase
        end
    end

    // Operation capture, scan, plan and table count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            ptr_reg         <= '0;
            dir_reg         <= SHIFT_NONE;
            w1_en_start_reg <= 1'b0;
            w1_en_last_reg  <= 1'b0;
            w2_en_reg       <= 1'b0;
            inc_reg         <= 1'b0;
            dec_reg         <= 1'b0;
            has_prev_reg    <= 1'b0;
            has_next_reg    <= 1'b0;
            has_best_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                ptr_reg      <= '0;
                has_prev_reg <= 1'b0;
                has_next_reg <= 1'b0;
                has_best_reg <= 1'b0;
                pos_reg      <= '0;
                dir_reg      <= SHIFT_NONE;
            end
            if (cmd.scan_rd || cmd.shift_rd)
            begin
                ptr_reg <= (dir_reg == SHIFT_UP) ? ptr_m1 : ptr_reg + cnt_t'(1);
            end
            // Each entry read in the scan updates neighbors and largest range.
            if (rd_scan_reg)
            begin
                if (rd_start_reg <= s_reg)
                begin
                    has_prev_reg   <= 1'b1;
                    prev_start_reg <= rd_start_reg;
                    prev_last_reg  <= rd_last_reg;
                    pos_reg        <= cnt_t'(rd_idx_reg) + cnt_t'(1);
                end
                else if (!has_next_reg)
                begin
                    has_next_reg   <= 1'b1;
                    next_start_reg <= rd_start_reg;
                    next_last_reg  <= rd_last_reg;
                end
                if (!has_best_reg || rd_size > best_size_reg)
                begin
                    has_best_reg  <= 1'b1;
                    best_size_reg <= rd_size;
                    best_last_reg <= rd_last_reg;
                end
            end
            if (cmd.decide)
            begin
                w1_en_start_reg <= p_w1_en_start;
                w1_en_last_reg  <= p_w1_en_last;
                dir_reg         <= p_dir;
                ptr_reg         <= p_ptr;
                w2_en_reg       <= p_w2_en;
                inc_reg         <= p_inc;
                dec_reg         <= p_dec;
            end
            if (cmd.done)
            begin
                dir_reg <= SHIFT_NONE;
                if (inc_reg)
                begin
                    count_reg <= count_reg + cnt_t'(1);
                end
                else if (dec_reg)
                begin
                    count_reg <= count_reg - cnt_t'(1);
                end
            end
        end
    end

    // Payload registers of the operation and plan.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            s_reg    <= range_start;
            l_reg    <= sum_l[ADDR_BITS] ? '1 : sum_l[ADDR_BITS-1:0];
            szm1_reg <= range_size - 32'd1;
            zero_reg <= (range_size == '0);
        end
        if (cmd.decide)
        begin
            w1_idx_reg   <= p_w1_pos[IDX_W-1:0];
            w1_start_reg <= p_w1_start;
            w1_last_reg  <= p_w1_last;
            shift_lo_reg <= pos_reg;
            w2_idx_reg   <= pos_reg[IDX_W-1:0];
            w2_start_reg <= p_w2_start;
            w2_last_reg  <= p_w2_last;
            stat_reg     <= p_stat;
            offset_reg   <= p_offset;
        end
    end

    // Result registers: one strobed transfer per operation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.done)
        begin
            found_offset_reg <= (stat_reg == STAT_OK) ? offset_reg : '0;
            status_reg       <= stat_reg;
            range_count_reg  <= inc_reg ? count_reg + cnt_t'(1)
                              : dec_reg ? count_reg - cnt_t'(1) : count_reg;
        end
    end

    assign done         = done_reg;
    assign found_offset = found_offset_reg;
    assign status       = status_reg;
    assign range_count  = range_count_reg;

    // Checks.
    `CFRA_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= cnt_t'(MAX_RANGES))
    `CFRA_ASSERT_SAME(a_wr_excl, clk, rst_n, rd_shift_reg, !cmd.write1 && !cmd.write2)
    `CFRA_ASSERT_SAME(a_rd_excl, clk, rst_n, cmd.scan_rd, !cmd.shift_rd)
    `CFRA_ASSERT_NEXT(a_done_strobe, clk, rst_n, cmd.done, done_reg)

endmodule

### hdl/coalescing_free_range_allocator.sv
// ----------------------------------------------------------------------------
// coalescing_free_range_allocator
// Sorted table of disjoint free ranges with add, take and find operations.
// ----------------------------------------------------------------------------
// Usage: an operation is taken at a rising edge where start is high and busy
// is low; mode, range_start and range_size are sampled at that edge. Mode 0
// adds a free range and merges it with touching neighbors, mode 1 takes a
// range out of the free range that holds it, mode 2 reports the end-aligned
// offset of a block carved from the largest free range.
// Each operation returns exactly one result transfer: done is high for one
// cycle with found_offset, status and range_count valid. The receiver cannot
// stall; the result is shown once. busy drops in the cycle done is high, so
// a new operation may start then.
// One pass reads all N stored ranges through the table's single read port to
// find neighbors and the largest range; inserts and removals then move up to
// N entries, one a cycle.
// One operation is in flight at a time.
// Reset clears the range count; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module coalescing_free_range_allocator
    import cfra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] range_start,
    input  logic [31:0] range_size,
    output logic        done,
    output logic [31:0] found_offset,
    output logic [2:0]  status,
    output logic [6:0]  range_count
);

    cfra_cmd_t  cmd;
    cfra_stat_t stat;

    // Sequencer.
    cfra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Table and arithmetic.
    cfra_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (mode),
        .range_start  (range_start),
        .range_size   (range_size),
        .done         (done),
        .found_offset (found_offset),
        .status       (status),
        .range_count  (range_count)
    );

endmodule
